// ===== rtl/json_string_unescaper_unit_defines.svh =====
// Assertion macros shared by the string unescaper RTL.
// Included by the top level; no other dependencies.
`ifndef JSON_STRING_UNESCAPER_UNIT_DEFINES_SVH
`define JSON_STRING_UNESCAPER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge, masked while reset is held.
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define JSU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define JSU_ASSERT(lbl, prop, msg)
`define JSU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the string unescaper.
// No dependencies.
package jsu_pkg;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_BYTE    = 3'd0,
        ST_CLOSED  = 3'd1,
        ST_NO_OPEN = 3'd2,
        ST_BAD_ESC = 3'd3,
        ST_BAD_HEX = 3'd4,
        ST_UNTERM  = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       input_ends;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] status;
        logic       last_of_run;
    } t_out_item;

    // One decoded input: one to three results that share a status.
    typedef struct packed {
        logic [1:0]      num;
        logic [2:0][7:0] bytes;
        t_status         status;
    } t_cmd;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] BS_BYTE  = 8'h08;
    localparam logic [7:0] FF_BYTE  = 8'h0C;
    localparam logic [7:0] LF_BYTE  = 8'h0A;
    localparam logic [7:0] CR_BYTE  = 8'h0D;
    localparam logic [7:0] TAB_BYTE = 8'h09;

    localparam logic [15:0] UTF8_LIM1  = 16'h0080;
    localparam logic [15:0] UTF8_LIM2  = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [7:0]  UTF8_MASK  = 8'h3F;

    // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/json_string_unescaper_unit.sv =====
`timescale 1ns / 1ps
// Top level of the JSON string unescaper: parser, request queue, serializer.
// Depends on jsu_pkg, jsu_front, jsu_cmd_fifo, jsu_back and the defines header.

// One raw byte is taken per cycle whenever full is low; the parser decides in
// that same cycle what the byte produces and queues one request of one to three
// results in a four-entry queue. Results leave one per cycle while the receiver
// pops, through a single output register, so a plain byte passes through the
// request queue and then the output register on its way to the result side, and
// the sustained rate is one input byte and one result per cycle while pop is held.
// A \uXXXX escape that needs three UTF-8 bytes holds the result side until all
// three have left; full rises only when the queue of requests fills behind a stalled pop.
// An item that produces no result (an opening quote, a backslash, the u of an
// escape, a hex digit short of the fourth, end of input while waiting) leaves nothing in the queue.
`include "json_string_unescaper_unit_defines.svh"

module json_string_unescaper_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  jsu_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output jsu_pkg::t_out_item  o_out_item
);
    import jsu_pkg::*;

    logic w_accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_fifo_full;
    logic w_fifo_empty;
    logic w_fifo_rd;
    t_cmd w_head_cmd;

    assign full     = w_fifo_full;
    assign w_accept = push && !w_fifo_full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    jsu_cmd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_accept && w_cmd_valid),
        .i_wr_cmd (w_cmd),
        .o_full   (w_fifo_full),
        .i_rd     (w_fifo_rd),
        .o_rd_cmd (w_head_cmd),
        .o_empty  (w_fifo_empty)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_fifo_empty),
        .i_cmd       (w_head_cmd),
        .o_cmd_rd    (w_fifo_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

    `JSU_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> empty && !full, "reset left results pending")
    `JSU_ASSERT(a_status_is_last, !empty && (o_out_item.status != ST_BYTE) |-> o_out_item.last_of_run, "status result not last of run")
    `JSU_ASSERT(a_run_still_queued, !empty && !o_out_item.last_of_run |-> !w_fifo_empty, "rest of a multi-byte run was lost")
    `JSU_ASSERT(a_no_read_when_empty, w_fifo_empty |-> !w_fifo_rd, "request queue read while empty")

endmodule

// ===== rtl/jsu_front.sv =====
`timescale 1ns / 1ps
// Front end: string parser that turns each accepted byte into at most one result request.
// Depends on jsu_pkg.
module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  jsu_pkg::t_in_item i_item,
    output logic            o_cmd_valid,
    output jsu_pkg::t_cmd   o_cmd
);
    import jsu_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [15:0] r_code_point, n_code_point;

    logic [7:0]  w_c;
    logic [4:0]  w_hex;
    logic [15:0] w_cp_next;

    assign w_c       = i_item.in_byte;
    assign w_hex     = hex_value(w_c);
    assign w_cp_next = {r_code_point[11:0], w_hex[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_hex_cnt    <= 2'd0;
            r_code_point <= 16'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_hex_cnt    <= n_hex_cnt;
            r_code_point <= n_code_point;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_hex_cnt    = r_hex_cnt;
        n_code_point = r_code_point;
        o_cmd_valid  = 1'b0;
        o_cmd        = '0;
        o_cmd.num    = 2'd1;
        o_cmd.status = ST_BYTE;

        if (i_item.input_ends) begin
            if (r_phase != PH_WAIT) begin
                o_cmd_valid  = 1'b1;
                o_cmd.status = ST_UNTERM;
            end
            n_phase      = PH_WAIT;
            n_hex_cnt    = 2'd0;
            n_code_point = 16'd0;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (w_c == CH_QUOTE) begin
                        n_phase = PH_STR;
                    end else begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.status = ST_NO_OPEN;
                    end
                end
                PH_STR: begin
                    if (w_c == CH_QUOTE) begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.status = ST_CLOSED;
                        n_phase      = PH_WAIT;
                    end else if (w_c == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        o_cmd_valid    = 1'b1;
                        o_cmd.bytes[0] = w_c;
                    end
                end
                PH_ESC: begin
                    n_phase     = PH_STR;
                    o_cmd_valid = 1'b1;
                    unique case (w_c)
                        CH_QUOTE:  o_cmd.bytes[0] = CH_QUOTE;
                        CH_BSLASH: o_cmd.bytes[0] = CH_BSLASH;
                        CH_SLASH:  o_cmd.bytes[0] = CH_SLASH;
                        CH_B:      o_cmd.bytes[0] = BS_BYTE;
                        CH_F:      o_cmd.bytes[0] = FF_BYTE;
                        CH_N:      o_cmd.bytes[0] = LF_BYTE;
                        CH_R:      o_cmd.bytes[0] = CR_BYTE;
                        CH_T:      o_cmd.bytes[0] = TAB_BYTE;
                        CH_U: begin
                            o_cmd_valid  = 1'b0;
                            n_phase      = PH_HEX;
                            n_hex_cnt    = 2'd0;
                            n_code_point = 16'd0;
                        end
                        default: begin
                            o_cmd.status = ST_BAD_ESC;
                            n_phase      = PH_WAIT;
                        end
                    endcase
                end
                PH_HEX: begin
                    if (!w_hex[4]) begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.status = ST_BAD_HEX;
                        n_phase      = PH_WAIT;
                        n_hex_cnt    = 2'd0;
                        n_code_point = 16'd0;
                    end else if (r_hex_cnt != 2'd3) begin
                        n_hex_cnt    = r_hex_cnt + 2'd1;
                        n_code_point = w_cp_next;
                    end else begin
                        // Fourth digit: encode the code point as UTF-8.
                        o_cmd_valid  = 1'b1;
                        n_phase      = PH_STR;
                        n_hex_cnt    = 2'd0;
                        n_code_point = 16'd0;
                        if (w_cp_next < UTF8_LIM1) begin
                            o_cmd.num      = 2'd1;
                            o_cmd.bytes[0] = w_cp_next[7:0];
                        end else if (w_cp_next < UTF8_LIM2) begin
                            o_cmd.num      = 2'd2;
                            o_cmd.bytes[0] = UTF8_LEAD2 | {3'd0, w_cp_next[10:6]};
                            o_cmd.bytes[1] = UTF8_CONT | (w_cp_next[7:0] & UTF8_MASK);
                        end else begin
                            o_cmd.num      = 2'd3;
                            o_cmd.bytes[0] = UTF8_LEAD3 | {4'd0, w_cp_next[15:12]};
                            o_cmd.bytes[1] = UTF8_CONT | (w_cp_next[13:6] & UTF8_MASK);
                            o_cmd.bytes[2] = UTF8_CONT | (w_cp_next[7:0] & UTF8_MASK);
                        end
                    end
                end
                default: begin
                    n_phase = PH_WAIT;
                end
            endcase
        end
    end

endmodule

// ===== rtl/jsu_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short request queue between the parser and the result serializer.
// Depends on jsu_pkg.
module jsu_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  jsu_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output jsu_pkg::t_cmd o_rd_cmd,
    output logic          o_empty
);
    import jsu_pkg::*;

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CMD_AW:0]   r_count;
    logic              w_do_wr, w_do_rd;

    assign o_full   = (r_count == (CMD_AW+1)'(CMD_DEPTH));
    assign o_empty  = (r_count == '0);
    assign w_do_wr  = i_wr && !o_full;
    assign w_do_rd  = i_rd && !o_empty;
    assign o_rd_cmd = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_wr) begin
                r_wr_ptr <= r_wr_ptr + CMD_AW'(1);
            end
            if (w_do_rd) begin
                r_rd_ptr <= r_rd_ptr + CMD_AW'(1);
            end
            if (w_do_wr && !w_do_rd) begin
                r_count <= r_count + (CMD_AW+1)'(1);
            end else if (w_do_rd && !w_do_wr) begin
                r_count <= r_count - (CMD_AW+1)'(1);
            end
        end
    end

endmodule

// ===== rtl/jsu_back.sv =====
`timescale 1ns / 1ps
// Back end: walks each queued request and emits its results into the output
// register one per cycle while it is free or being popped. Depends on jsu_pkg.
module jsu_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_empty,
    input  jsu_pkg::t_cmd     i_cmd,
    output logic              o_cmd_rd,
    output logic              o_empty,
    input  logic              i_pop,
    output jsu_pkg::t_out_item o_item
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_out_item  r_item;
    logic       w_load, w_last, w_pop_acc;
    logic [7:0] w_byte;

    assign w_pop_acc = i_pop && r_valid;
    // The output register refills whenever it is free or being drained.
    assign w_load    = !i_cmd_empty && (!r_valid || w_pop_acc);
    assign w_last    = (r_idx == (i_cmd.num - 2'd1));
    assign o_cmd_rd  = w_load && w_last;
    assign o_empty   = !r_valid;
    assign o_item    = r_item;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_byte = i_cmd.bytes[0];
            2'd1:    w_byte = i_cmd.bytes[1];
            2'd2:    w_byte = i_cmd.bytes[2];
            default: w_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.out_byte    <= w_byte;
            r_item.status      <= i_cmd.status;
            r_item.last_of_run <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 2'd0 : r_idx + 2'd1;
            end else if (w_pop_acc) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for json_string_unescaper_unit: quoted strings go in
// byte by byte, and each decoded result is compared with a prediction in order.
// Depends on jsu_pkg and the unescaper RTL.
module testbench;
    import jsu_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_OFF_CYCLES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    t_in_item  i_in_item = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    // Predicted decoder state.
    t_phase      parse_phase = PH_WAIT;
    logic [1:0]  nibble_count = 2'd0;
    logic [15:0] gathered_cp = 16'd0;

    t_out_item pending_out[$];
    t_out_item want_item;
    int        error_count = 0;
    int        accepted_in = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_off_req = 0;
    int        hold_off_left = 0;

    logic [7:0] esc_letters[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    json_string_unescaper_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return "0" + {4'd0, v};
        return (upper ? "A" : "a") + {4'd0, v - 4'd10};
    endfunction

    function automatic bit is_esc_letter(input logic [7:0] c);
        foreach (esc_letters[i]) begin
            if (c == esc_letters[i]) return 1'b1;
        end
        return c == CH_U;
    endfunction

    function automatic t_out_item make_result(input logic [7:0] b, input t_status s);
        t_out_item r;
        r.out_byte = b;
        r.status = s;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    // Advances the predicted state by one accepted request and queues its results.
    task automatic unescape_step(input t_in_item it);
        t_out_item   run[$];
        t_out_item   r;
        logic [7:0]  c;
        logic [15:0] cp;
        int          d;
        c = it.in_byte;
        if (it.input_ends) begin
            if (parse_phase != PH_WAIT) run = {run, make_result(8'h00, ST_UNTERM)};
            parse_phase = PH_WAIT;
            nibble_count = 2'd0;
            gathered_cp = 16'd0;
        end else begin
            case (parse_phase)
                PH_WAIT: begin
                    if (c == CH_QUOTE) parse_phase = PH_STR;
                    else run = {run, make_result(8'h00, ST_NO_OPEN)};
                end
                PH_STR: begin
                    if (c == CH_QUOTE) begin
                        run = {run, make_result(8'h00, ST_CLOSED)};
                        parse_phase = PH_WAIT;
                    end else if (c == CH_BSLASH) begin
                        parse_phase = PH_ESC;
                    end else begin
                        run = {run, make_result(c, ST_BYTE)};
                    end
                end
                PH_ESC: begin
                    parse_phase = PH_STR;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: run = {run, make_result(c, ST_BYTE)};
                        CH_B: run = {run, make_result(BS_BYTE, ST_BYTE)};
                        CH_F: run = {run, make_result(FF_BYTE, ST_BYTE)};
                        CH_N: run = {run, make_result(LF_BYTE, ST_BYTE)};
                        CH_R: run = {run, make_result(CR_BYTE, ST_BYTE)};
                        CH_T: run = {run, make_result(TAB_BYTE, ST_BYTE)};
                        CH_U: begin
                            parse_phase = PH_HEX;
                            nibble_count = 2'd0;
                            gathered_cp = 16'd0;
                        end
                        default: begin
                            run = {run, make_result(8'h00, ST_BAD_ESC)};
                            parse_phase = PH_WAIT;
                        end
                    endcase
                end
                default: begin
                    d = nibble_of(c);
                    if (d < 0) begin
                        run = {run, make_result(8'h00, ST_BAD_HEX)};
                        parse_phase = PH_WAIT;
                        nibble_count = 2'd0;
                        gathered_cp = 16'd0;
                    end else if (nibble_count != 2'd3) begin
                        gathered_cp = {gathered_cp[11:0], 4'(d)};
                        nibble_count = nibble_count + 2'd1;
                    end else begin
                        cp = {gathered_cp[11:0], 4'(d)};
                        if (cp < UTF8_LIM1) begin
                            run = {run, make_result(cp[7:0], ST_BYTE)};
                        end else if (cp < UTF8_LIM2) begin
                            run = {run, make_result(UTF8_LEAD2 | {3'd0, cp[10:6]}, ST_BYTE)};
                            run = {run, make_result(UTF8_CONT | (cp[7:0] & UTF8_MASK),
                                                    ST_BYTE)};
                        end else begin
                            run = {run, make_result(UTF8_LEAD3 | {4'd0, cp[15:12]}, ST_BYTE)};
                            run = {run, make_result(UTF8_CONT | {2'd0, cp[11:6]}, ST_BYTE)};
                            run = {run, make_result(UTF8_CONT | {2'd0, cp[5:0]}, ST_BYTE)};
                        end
                        parse_phase = PH_STR;
                        nibble_count = 2'd0;
                        gathered_cp = 16'd0;
                    end
                end
            endcase
        end
        for (int i = 0; i < run.size(); i++) begin
            r = run[i];
            r.last_of_run = (i == run.size() - 1);
            pending_out = {pending_out, r};
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offers one request and returns once it has been accepted.
    task automatic send_item(input logic [7:0] b, input logic ends);
        t_in_item it;
        bit       taken;
        it.in_byte = b;
        it.input_ends = ends;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle_pct) begin
                push <= 1'b0;
            end else begin
                push <= 1'b1;
                i_in_item <= it;
                @(posedge i_clk);
                while (full) @(posedge i_clk);
                taken = 1'b1;
            end
        end
        unescape_step(it);
        accepted_in++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    task automatic send_end();
        send_item(8'($urandom), 1'b1);
    endtask

    task automatic send_unicode(input logic [15:0] cp);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--) begin
            send_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(1))));
        end
    endtask

    task automatic test_directed();
        send_end();                       // end of input with no string open
        send_byte("a");                   // missing opening quote
        send_byte(CH_QUOTE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_byte("q");                   // unknown escape letter
        send_byte(CH_QUOTE);
        send_unicode(16'h0000);           // code point zero gives a zero byte
        send_unicode(16'hFFFF);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_byte("g");                   // non-hex digit inside the escape
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_end();                       // end right after a backslash
        send_byte(CH_QUOTE);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_byte("A");
        send_end();                       // end among the hex digits
        send_byte(CH_QUOTE);
        send_end();                       // end inside the plain string
    endtask

    // One string, well formed most of the time, otherwise broken or noise.
    task automatic send_random_string();
        logic [7:0]  b;
        logic [15:0] cp;
        int          len;
        int          pick;
        if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(3) == 0) begin
                    send_end();
                end else begin
                    b = 8'($urandom);
                    if (b == CH_QUOTE) b = b ^ 8'h01;
                    send_byte(b);
                end
            end
            return;
        end
        send_byte(CH_QUOTE);
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                b = 8'($urandom);
                if (b == CH_QUOTE || b == CH_BSLASH) b = b ^ 8'h01;
                send_byte(b);
            end else if (pick < 75) begin
                send_byte(CH_BSLASH);
                send_byte(esc_letters[$urandom_range(7)]);
            end else if (pick < 95) begin
                case ($urandom_range(2))
                    0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                    1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                    default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                endcase
                send_unicode(cp);
            end else begin
                case ($urandom_range(2))
                    0: begin
                        send_byte(CH_BSLASH);
                        do b = 8'($urandom); while (is_esc_letter(b));
                        send_byte(b);
                    end
                    1: begin
                        send_byte(CH_BSLASH);
                        send_byte(CH_U);
                        repeat ($urandom_range(0, 3)) begin
                            send_byte(hex_char(4'($urandom), 1'($urandom_range(1))));
                        end
                        do b = 8'($urandom); while (nibble_of(b) >= 0);
                        send_byte(b);
                    end
                    default: send_end();
                endcase
                return;
            end
        end
        if ($urandom_range(9) == 0) send_end();
        else send_byte(CH_QUOTE);
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int items);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = accepted_in + items;
        while (accepted_in < target) send_random_string();
    endtask

    // The receiver holds off while a long string keeps coming, so the block fills.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = HOLD_OFF_CYCLES;
        send_byte(CH_QUOTE);
        repeat (40) begin
            send_byte(8'($urandom_range(8'h23, 8'h5B)));
        end
        send_unicode(16'h20AC);
        send_byte(CH_QUOTE);
    endtask

    // Receiver side: random idling plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (hold_off_left == 0 && hold_off_req > 0) begin
            hold_off_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_out.size() == 0) begin
                report_mismatch("unexpected result, status", o_out_item.status, 0);
            end else begin
                want_item = pending_out.pop_front();
                if (o_out_item.out_byte !== want_item.out_byte)
                    report_mismatch("out_byte", o_out_item.out_byte, want_item.out_byte);
                if (o_out_item.status !== want_item.status)
                    report_mismatch("status", o_out_item.status, want_item.status);
                if (o_out_item.last_of_run !== want_item.last_of_run)
                    report_mismatch("last_of_run", o_out_item.last_of_run,
                                    want_item.last_of_run);
            end
        end
    end

    // Watchdog: ends the run when no request moves on either side for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 13;
        recv_idle_pct = 77;
        test_directed();
        test_random(13, 77, 75);
        test_random(77, 13, 75);
        test_random(0, 0, 75);
        test_backpressure();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_out.size() != 0)
            report_mismatch("results left over", 0, pending_out.size());
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_cmd_fifo.sv
rtl/jsu_back.sv
rtl/json_string_unescaper_unit.sv
test/testbench.sv
